// ----- rtl/core/sprdec_pkg.sv -----
package sprdec_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int unsigned COLOR_W         = 16;
  localparam int unsigned DIM_W           = 12;

  // request kinds
  localparam logic [1:0] REQ_PALETTE   = 2'd0;
  localparam logic [1:0] REQ_ROW_START = 2'd1;
  localparam logic [1:0] REQ_CODE      = 2'd2;
  localparam logic [1:0] REQ_FRAME_END = 2'd3;

  // result kinds
  localparam logic RES_PIXEL  = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PAL_AW-1:0]  palette_index;
    logic [COLOR_W-1:0] palette_color;
    logic [DIM_W-1:0]   row_number;
    logic [7:0]         code_byte;
  } req_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [DIM_W-1:0] pixel_x;
    logic [DIM_W-1:0] pixel_y;
    logic [31:0]      argb;
    logic             interlaced;
    logic             last;
  } rsp_item_t;

  // 5:6:5-ish color expanded into the low 24 bits; the source bit fields overlap
  function automatic logic [31:0] make_argb(input logic [COLOR_W-1:0] c,
                                            input logic [7:0] a);
    make_argb = {a, c[15:11], c[13:5], c[6:0], c[2:0]};
  endfunction

endpackage

// ----- rtl/core/sprdec_if.sv -----
interface sprdec_req_if;
  import sprdec_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface sprdec_rsp_if;
  import sprdec_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface sprdec_cfg_if;
  import sprdec_pkg::*;
  logic             valid;
  logic             ready;
  logic             index;
  logic [DIM_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sprite_rle_line_decoder.sv -----
// Run-length sprite row decoder.
// cfg: register writes (index 0 frame width, 1 frame height), always ready;
//   write only while the block is idle.
// req: one transaction per item: palette write, row start, code byte or frame
//   end. Palette writes go straight into the palette RAM.
// rsp: pixel results (x, y, ARGB) and frame status results; last marks the
//   final result of an item.
// Items: palette write and row start complete in S_IDLE when taken. A code byte
//   passes S_WORK after the registered palette RAM read; frame end waits there
//   for a free output slot. A code byte that places pixels in the row (the
//   index byte of a single, run, repeat or literal code; a zero-alpha pixel
//   moves the column without a write) runs the emit loop: one pixel per cycle,
//   stalled while a drawn pixel has no free output slot, then the row check.
// A full output register sits on rsp; the next item is taken while the last
//   result still waits. A stalled receiver holds the emit loop and the frame
//   status in place, with no loss.
// Reset (rst, synchronous) clears control and decoder state but not the item,
//   emit data and output item registers; no row is open and the interlace flag
//   is set. Palette contents are undefined until written; no clearing pass is run.
module sprite_rle_line_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input logic          clk,
  input logic          rst,
  sprdec_cfg_if.sink   cfg,
  sprdec_req_if.sink   req,
  sprdec_rsp_if.source rsp
);
  import sprdec_pkg::*;

  localparam int unsigned ROW_MASK_FULL = MAX_DIM - 1;
  localparam logic [DIM_W-1:0] ROW_MASK = DIM_W'(ROW_MASK_FULL);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef enum logic [5:0] {
    PH_CODE         = 6'b000001,
    PH_ONE_INDEX    = 6'b000010,
    PH_RUN_ALPHA    = 6'b000100,
    PH_RUN_INDEX    = 6'b001000,
    PH_LITERAL      = 6'b010000,
    PH_REPEAT_INDEX = 6'b100000
  } phase_t;

  state_t           state, state_next;
  phase_t           decode_phase, decode_phase_next;
  logic [DIM_W-1:0] frame_width, frame_height;
  logic [DIM_W-1:0] current_row, current_row_next;
  logic [DIM_W:0]   current_col, current_col_next;
  logic [5:0]       pending_count, pending_count_next;
  logic [7:0]       held_alpha, held_alpha_next;
  logic             row_finished, row_finished_next;
  logic             interlace_flag, interlace_flag_next;
  logic [1:0]       item_kind, item_kind_next;
  logic [7:0]       item_byte, item_byte_next;
  logic [5:0]       emit_cnt, emit_cnt_next;
  logic             emit_draw, emit_draw_next;
  logic [7:0]       emit_alpha, emit_alpha_next;
  logic             out_valid, out_valid_next;
  rsp_item_t        out_item, out_item_next;

  logic               accept;
  logic               slot_free;
  logic               in_frame;
  logic               col_over;
  logic [DIM_W:0]     col_plus1;
  logic [7:0]         held_scaled;
  logic [5:0]         pending_dec;
  logic               ram_we, ram_re;
  logic [COLOR_W-1:0] pal_rdata;

  sprdec_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(req.item.palette_index),
    .wdata(req.item.palette_color),
    .re   (ram_re),
    .raddr(req.item.code_byte),
    .rdata(pal_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.item  = out_item;

  assign accept      = req.valid && req.ready;
  assign slot_free   = !out_valid || rsp.ready;
  assign col_over    = current_col >= {1'b0, frame_width};
  assign in_frame    = !col_over && (current_row < frame_height);
  assign col_plus1   = current_col + 1'b1;
  assign held_scaled = (held_alpha != 8'd0) ? ({held_alpha[4:0], 3'b000} - 8'd7) : 8'd0;
  assign pending_dec = pending_count - 6'd1;

  always_comb begin
    state_next          = state;
    decode_phase_next   = decode_phase;
    current_row_next    = current_row;
    current_col_next    = current_col;
    pending_count_next  = pending_count;
    held_alpha_next     = held_alpha;
    row_finished_next   = row_finished;
    interlace_flag_next = interlace_flag;
    item_kind_next      = item_kind;
    item_byte_next      = item_byte;
    emit_cnt_next       = emit_cnt;
    emit_draw_next      = emit_draw;
    emit_alpha_next     = emit_alpha;
    out_valid_next      = out_valid && !rsp.ready;
    out_item_next       = out_item;
    ram_we              = 1'b0;
    ram_re              = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          item_kind_next = req.item.req_type;
          item_byte_next = req.item.code_byte;
          case (req.item.req_type)
            REQ_PALETTE: begin
              ram_we = 1'b1;
            end
            REQ_ROW_START: begin
              current_row_next   = req.item.row_number & ROW_MASK;
              current_col_next   = '0;
              decode_phase_next  = PH_CODE;
              pending_count_next = '0;
              held_alpha_next    = '0;
              row_finished_next  = (frame_width == '0);
            end
            REQ_CODE: begin
              ram_re     = 1'b1;
              state_next = S_WORK;
            end
            default: begin
              state_next = S_WORK;
            end
          endcase
        end
      end

      S_WORK: begin
        if (item_kind == REQ_FRAME_END) begin
          if (slot_free) begin
            out_valid_next            = 1'b1;
            out_item_next             = '0;
            out_item_next.result_kind = RES_STATUS;
            out_item_next.interlaced  = interlace_flag;
            out_item_next.last        = 1'b1;
            interlace_flag_next       = 1'b1;
            row_finished_next         = 1'b1;
            decode_phase_next         = PH_CODE;
            pending_count_next        = '0;
            held_alpha_next           = '0;
            state_next                = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
          if (row_finished) begin
            // no open row: byte dropped
          end else if (decode_phase == PH_CODE && col_over) begin
            row_finished_next = 1'b1;
          end else begin
            case (decode_phase)
              PH_CODE: begin
                if (item_byte == 8'h00) begin
                  row_finished_next = 1'b1;
                end else begin
                  case (item_byte[7:6])
                    2'b00: begin
                      if (current_row[0]) interlace_flag_next = 1'b0;
                      if (item_byte[5]) begin
                        held_alpha_next   = {3'b000, item_byte[4:0]};
                        decode_phase_next = PH_ONE_INDEX;
                      end else begin
                        pending_count_next = {1'b0, item_byte[4:0]};
                        decode_phase_next  = PH_RUN_ALPHA;
                      end
                    end
                    2'b01: begin
                      if (current_row[0]) interlace_flag_next = 1'b0;
                      pending_count_next = item_byte[5:0];
                      if (item_byte[5:0] != 6'd0) decode_phase_next = PH_LITERAL;
                    end
                    2'b10: begin
                      if (current_row[0]) interlace_flag_next = 1'b0;
                      pending_count_next = item_byte[5:0];
                      decode_phase_next  = PH_REPEAT_INDEX;
                    end
                    default: begin
                      current_col_next = current_col + {7'd0, item_byte[5:0]};
                    end
                  endcase
                  if (decode_phase_next == PH_CODE &&
                      current_col_next >= {1'b0, frame_width}) begin
                    row_finished_next = 1'b1;
                  end
                end
              end
              PH_RUN_ALPHA: begin
                held_alpha_next   = item_byte;
                decode_phase_next = PH_RUN_INDEX;
              end
              PH_ONE_INDEX: begin
                emit_cnt_next     = 6'd1;
                emit_draw_next    = (held_alpha != 8'd0);
                emit_alpha_next   = held_scaled;
                decode_phase_next = PH_CODE;
                state_next        = S_EMIT;
              end
              PH_RUN_INDEX: begin
                emit_cnt_next      = pending_count;
                emit_draw_next     = 1'b1;
                emit_alpha_next    = held_scaled;
                pending_count_next = '0;
                decode_phase_next  = PH_CODE;
                state_next         = S_EMIT;
              end
              PH_LITERAL: begin
                emit_cnt_next      = 6'd1;
                emit_draw_next     = 1'b1;
                emit_alpha_next    = 8'hFF;
                pending_count_next = pending_dec;
                if (pending_dec == 6'd0) decode_phase_next = PH_CODE;
                state_next         = S_EMIT;
              end
              PH_REPEAT_INDEX: begin
                emit_cnt_next      = pending_count;
                emit_draw_next     = 1'b1;
                emit_alpha_next    = 8'hFF;
                pending_count_next = '0;
                decode_phase_next  = PH_CODE;
                state_next         = S_EMIT;
              end
              default: begin
                decode_phase_next = PH_CODE;
              end
            endcase
          end
        end
      end

      S_EMIT: begin
        if (emit_cnt == 6'd0 || !in_frame) begin
          if (decode_phase == PH_CODE && col_over) row_finished_next = 1'b1;
          state_next = S_IDLE;
        end else if (!emit_draw) begin
          // zero-alpha single pixel: column moves, nothing written
          current_col_next = col_plus1;
          emit_cnt_next    = emit_cnt - 6'd1;
        end else if (slot_free) begin
          out_valid_next            = 1'b1;
          out_item_next.result_kind = RES_PIXEL;
          out_item_next.pixel_x     = current_col[DIM_W-1:0];
          out_item_next.pixel_y     = current_row;
          out_item_next.argb        = make_argb(pal_rdata, emit_alpha);
          out_item_next.interlaced  = 1'b0;
          out_item_next.last        = (emit_cnt == 6'd1) || (col_plus1 >= {1'b0, frame_width});
          current_col_next          = col_plus1;
          emit_cnt_next             = emit_cnt - 6'd1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      decode_phase   <= PH_CODE;
      frame_width    <= '0;
      frame_height   <= '0;
      current_row    <= '0;
      current_col    <= '0;
      pending_count  <= '0;
      held_alpha     <= '0;
      row_finished   <= 1'b1;
      interlace_flag <= 1'b1;
      emit_cnt       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      decode_phase   <= decode_phase_next;
      current_row    <= current_row_next;
      current_col    <= current_col_next;
      pending_count  <= pending_count_next;
      held_alpha     <= held_alpha_next;
      row_finished   <= row_finished_next;
      interlace_flag <= interlace_flag_next;
      emit_cnt       <= emit_cnt_next;
      out_valid      <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
          CFG_FRAME_HEIGHT: frame_height <= cfg.data;
          default:          frame_width  <= frame_width;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_kind  <= item_kind_next;
    item_byte  <= item_byte_next;
    emit_draw  <= emit_draw_next;
    emit_alpha <= emit_alpha_next;
    out_item   <= out_item_next;
  end

  // a closed row never leaves a multi-byte code open
  a_finished_phase: assert property (@(posedge clk) disable iff (rst)
    row_finished |-> decode_phase == PH_CODE)
    else $error("row closed with code in progress");

  // pixels shown on rsp lie inside the frame
  a_pixel_in_frame: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.item.result_kind == RES_PIXEL) |->
      ({1'b0, rsp.item.pixel_x} < {1'b0, frame_width} && rsp.item.pixel_y < frame_height))
    else $error("pixel outside frame");

  // frame status is a single, final result with no pixel data
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.item.result_kind == RES_STATUS) |->
      (rsp.item.last && rsp.item.argb == 32'd0))
    else $error("malformed frame status");

  // a drawn pixel is loaded into the output register in the next cycle
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_cnt != 6'd0 && in_frame && emit_draw && slot_free) |=>
      (rsp.valid && rsp.item.result_kind == RES_PIXEL))
    else $error("pixel not loaded");

endmodule

// ----- rtl/core/sprdec_ram.sv -----
module sprdec_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
